@@ rtl/oqkr_pkg.sv @@
// ----------------------------------------------------------------------------
// oqkr_pkg
// Shared sizes, codes and types of the ordered queue with keyed removal.
// ----------------------------------------------------------------------------
package oqkr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int POS_W       = 4;
    localparam int OUT_CNT_W   = 5;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
        logic sel;
    } t_cell_ctl;

    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[POS_W-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[OUT_CNT_W-1:0];
    endfunction

endpackage

@@ rtl/oqkr_cell.sv @@
// ----------------------------------------------------------------------------
// oqkr_cell
// One queue slot: holds a key, loads a pushed key, takes its right
// neighbor's key when the queue closes a gap, and compares when selected.
// ----------------------------------------------------------------------------
module oqkr_cell (
    input  logic                       i_clk,
    input  oqkr_pkg::t_cell_ctl        i_ctl,
    input  logic [oqkr_pkg::KEY_W-1:0] i_load_key,
    input  logic [oqkr_pkg::KEY_W-1:0] i_next_key,
    input  logic [oqkr_pkg::KEY_W-1:0] i_cmp_key,
    output logic [oqkr_pkg::KEY_W-1:0] o_key,
    output logic                       o_hit
);

    logic [oqkr_pkg::KEY_W-1:0] r_key;
    logic [oqkr_pkg::KEY_W-1:0] n_key;

    always_comb begin
        if (i_ctl.load) begin
            n_key = i_load_key;
        end else if (i_ctl.shift) begin
            n_key = i_next_key;
        end else begin
            n_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_hit = i_ctl.sel && (r_key == i_cmp_key);

endmodule

@@ rtl/ordered_queue_keyed_removal_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_queue_keyed_removal_unit
// Ordered key queue built as a row of slots; push at the tail, find or
// remove the first matching key from the front, closing the gap.
//
// channel   direction  handshake            payload
// request   in         start && !busy       i_req_type, i_key
// result    out        o_done (one cycle)   o_status, o_key_out, o_position,
//                                           o_entry_count, o_not_empty
//
// A push, or a find/remove on an empty queue, skips the scan and busy stays
// low. A find/remove scans one slot a cycle from the front until a match, or
// a miss at the last entry, ends it with a registered result.
// Synchronous active-low reset empties the queue. Results cannot be stalled.
// ----------------------------------------------------------------------------
module ordered_queue_keyed_removal_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_req_type,
    input  logic [oqkr_pkg::KEY_W-1:0]     i_key,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [oqkr_pkg::KEY_W-1:0]     o_key_out,
    output logic [oqkr_pkg::POS_W-1:0]     o_position,
    output logic [oqkr_pkg::OUT_CNT_W-1:0] o_entry_count,
    output logic                           o_not_empty
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                           r_state;
    t_state                           n_state;
    logic [oqkr_pkg::CNT_W-1:0]       r_count;
    logic [oqkr_pkg::CNT_W-1:0]       n_count;
    logic [oqkr_pkg::IDX_W-1:0]       r_pos;
    logic [oqkr_pkg::IDX_W-1:0]       n_pos;
    logic                             r_remove;
    logic [oqkr_pkg::KEY_W-1:0]       r_req_key;

    logic                             r_done;
    logic                             n_done;
    logic [1:0]                       r_status;
    logic [1:0]                       n_status;
    logic [oqkr_pkg::KEY_W-1:0]       r_key_out;
    logic [oqkr_pkg::KEY_W-1:0]       n_key_out;
    logic [oqkr_pkg::POS_W-1:0]       r_position;
    logic [oqkr_pkg::POS_W-1:0]       n_position;

    logic                             accept;
    logic                             is_push;
    logic                             full;
    logic                             hit;
    logic                             last;
    logic [oqkr_pkg::QUEUE_DEPTH-1:0] hit_vec;
    oqkr_pkg::t_cell_ctl              ctl [oqkr_pkg::QUEUE_DEPTH];
    logic [oqkr_pkg::KEY_W-1:0]       cell_key [oqkr_pkg::QUEUE_DEPTH+1];

    assign busy    = (r_state == ST_SCAN);
    assign accept  = start && !busy;
    assign is_push = (i_req_type == oqkr_pkg::REQ_PUSH);
    assign full    = (r_count == oqkr_pkg::CNT_W'(oqkr_pkg::QUEUE_DEPTH));
    assign hit     = busy && (|hit_vec);
    assign last    = ((oqkr_pkg::CNT_W'(r_pos) + oqkr_pkg::CNT_W'(1)) == r_count);

    assign cell_key[oqkr_pkg::QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < oqkr_pkg::QUEUE_DEPTH; g++) begin : g_cell
        always_comb begin
            ctl[g].load  = accept && is_push && !full &&
                           (r_count == oqkr_pkg::CNT_W'(g));
            ctl[g].sel   = busy && (r_pos == oqkr_pkg::IDX_W'(g));
            ctl[g].shift = hit && r_remove && (oqkr_pkg::IDX_W'(g) >= r_pos);
        end

        oqkr_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl[g]),
            .i_load_key (i_key),
            .i_next_key (cell_key[g+1]),
            .i_cmp_key  (r_req_key),
            .o_key      (cell_key[g]),
            .o_hit      (hit_vec[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_done     = 1'b0;
        n_status   = r_status;
        n_key_out  = r_key_out;
        n_position = r_position;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pos = '0;
                    if (is_push) begin
                        n_done     = 1'b1;
                        n_key_out  = '0;
                        if (full) begin
                            n_status   = oqkr_pkg::STAT_FULL;
                            n_position = '0;
                        end else begin
                            n_status   = oqkr_pkg::STAT_OK;
                            n_position = oqkr_pkg::to_pos(r_count[oqkr_pkg::IDX_W-1:0]);
                            n_count    = r_count + oqkr_pkg::CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_done     = 1'b1;
                        n_status   = oqkr_pkg::STAT_EMPTY;
                        n_key_out  = '0;
                        n_position = '0;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_done     = 1'b1;
                    n_status   = oqkr_pkg::STAT_OK;
                    n_key_out  = r_req_key;
                    n_position = oqkr_pkg::to_pos(r_pos);
                    n_state    = ST_IDLE;
                    if (r_remove) begin
                        n_count = r_count - oqkr_pkg::CNT_W'(1);
                    end
                end else if (last) begin
                    n_done     = 1'b1;
                    n_status   = oqkr_pkg::STAT_NOT_FOUND;
                    n_key_out  = '0;
                    n_position = '0;
                    n_state    = ST_IDLE;
                end else begin
                    n_pos = r_pos + oqkr_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_key_out  <= n_key_out;
        r_position <= n_position;
        if (accept) begin
            r_remove  <= (i_req_type == oqkr_pkg::REQ_REMOVE);
            r_req_key <= i_key;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_key_out     = r_key_out;
    assign o_position    = r_position;
    assign o_entry_count = oqkr_pkg::to_out_cnt(r_count);
    assign o_not_empty   = (r_count != '0);

endmodule
